@@ hw/rtl/imk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imk_pkg: shared types and codes for the iambic Morse keyer
// Tick width, element/class/edge codes, register indexes and the state,
// configuration and result structures passed between modules.
// ----------------------------------------------------------------------------
package imk_pkg;

  localparam int TICK_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef logic [TICK_WIDTH-1:0] tick_t;

  typedef enum logic [1:0] {
    ELEM_NONE = 2'd0,
    ELEM_DIT  = 2'd1,
    ELEM_DAH  = 2'd2
  } elem_t;

  typedef enum logic [1:0] {
    CLS_OFF         = 2'd0,
    CLS_ON          = 2'd1,
    CLS_OFF_CHANGED = 2'd2,
    CLS_ON_CHANGED  = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_t;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_DIT_TICKS   = 3'd0,
    CFG_DAH_TICKS   = 3'd1,
    CFG_GAP_TICKS   = 3'd2,
    CFG_LEAD_TICKS  = 3'd3,
    CFG_IAMBIC_MODE = 3'd4,
    CFG_PADDLE_SWAP = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    tick_t dit_ticks;
    tick_t dah_ticks;
    tick_t gap_ticks;
    tick_t lead_ticks;
    logic  iambic_mode;
    logic  paddle_swap;
  } cfg_t;

  typedef struct packed {
    logic  dit_level_prev;
    logic  dah_level_prev;
    logic  dit_pending;
    logic  dah_pending;
    logic  dit_keyed;
    logic  dah_keyed;
    tick_t element_start;
    tick_t element_end;
    elem_t last_element;
  } state_t;

  typedef struct packed {
    logic  dah_waiting;
    logic  dit_waiting;
    elem_t current_element;
    edge_t key_edge;
  } result_t;

endpackage

@@ hw/rtl/iambic_morse_keyer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_morse_keyer: iambic paddle keyer with tick-based element scheduling
// Usage:
//   s_* carries one word per tick: the tick count and the two paddle levels.
//   m_* returns one word per input word: key edge, current element and the
//   two pending flags after that tick.
//   cfg_* writes the registers (0 dit, 1 dah, 2 gap, 3 lead, 4 iambic mode,
//   5 paddle swap); it is always ready, other indexes are ignored. Write only
//   while no word is in flight.
// Timing:
//   An accepted word lands in the input register; the scheduler runs on it
//   and the result is captured in the output register. One word per clock is
//   sustained while the output is not stalled: the scheduler and state update
//   form one register-to-register pass, so the next word sees the updated state.
// Reset: rst clears all keyer state and sets iambic mode; the lengths are 0.
// Stall: while m_tready is low the result holds, one more word waits in the
//   input register, then s_tready drops.
// ----------------------------------------------------------------------------
module iambic_morse_keyer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [39:0]                        s_tdata,   // now_ticks[31:0], dit_pressed,
                                                        // dah_pressed, zero pad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // key_edge[1:0],
                                                        // current_element[1:0],
                                                        // dit_waiting, dah_waiting,
                                                        // zero pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imk_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [imk_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

  imk_pkg::cfg_t    cfg;
  imk_pkg::state_t  state;
  imk_pkg::state_t  state_next;
  imk_pkg::result_t res_next;
  imk_pkg::result_t res;

  logic             in_valid;
  imk_pkg::tick_t   in_now;
  logic             in_dit;
  logic             in_dah;
  logic             advance;

  imk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imk_sched u_sched (
    .cfg         (cfg),
    .cur         (state),
    .now_ticks   (in_now),
    .dit_pressed (in_dit),
    .dah_pressed (in_dah),
    .nxt         (state_next),
    .res         (res_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_now <= s_tdata[imk_pkg::TICK_WIDTH-1:0];
      in_dit <= s_tdata[32];
      in_dah <= s_tdata[33];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {2'b00, res};

endmodule

@@ hw/rtl/imk_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imk_cfg: keyer configuration registers
// Holds element lengths, gap, lead and mode bits; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module imk_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imk_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [imk_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  output imk_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dit_ticks   <= '0;
      cfg.dah_ticks   <= '0;
      cfg.gap_ticks   <= '0;
      cfg.lead_ticks  <= '0;
      cfg.iambic_mode <= 1'b1;
      cfg.paddle_swap <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        imk_pkg::CFG_DIT_TICKS:   cfg.dit_ticks   <= cfg_data;
        imk_pkg::CFG_DAH_TICKS:   cfg.dah_ticks   <= cfg_data;
        imk_pkg::CFG_GAP_TICKS:   cfg.gap_ticks   <= cfg_data;
        imk_pkg::CFG_LEAD_TICKS:  cfg.lead_ticks  <= cfg_data;
        imk_pkg::CFG_IAMBIC_MODE: cfg.iambic_mode <= cfg_data[0];
        imk_pkg::CFG_PADDLE_SWAP: cfg.paddle_swap <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/imk_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imk_sched: per-tick element scheduler
// Classifies both paddles, handles them in priority order, schedules the
// next element and works out the key edge. Pure combinational next state.
// ----------------------------------------------------------------------------
module imk_sched (
  input  imk_pkg::cfg_t   cfg,
  input  imk_pkg::state_t cur,
  input  imk_pkg::tick_t  now_ticks,
  input  logic            dit_pressed,
  input  logic            dah_pressed,
  output imk_pkg::state_t nxt,
  output imk_pkg::result_t res
);

  function automatic imk_pkg::cls_t classify(input logic level, input logic prev);
    if (level == prev) begin
      return level ? imk_pkg::CLS_ON : imk_pkg::CLS_OFF;
    end
    return level ? imk_pkg::CLS_ON_CHANGED : imk_pkg::CLS_OFF_CHANGED;
  endfunction

  // One paddle: may schedule an element after the previous one plus the gap.
  function automatic imk_pkg::state_t handle(input imk_pkg::state_t s,
                                             input imk_pkg::elem_t elem,
                                             input imk_pkg::cls_t cls,
                                             input imk_pkg::tick_t len,
                                             input imk_pkg::tick_t now,
                                             input imk_pkg::cfg_t c);
    imk_pkg::state_t r;
    imk_pkg::tick_t  free_at;
    imk_pkg::tick_t  limit;
    imk_pkg::tick_t  start;
    logic            ok;
    logic            mine;
    logic            other;
    logic            mine_n;
    logic            go;
    r       = s;
    free_at = s.element_end + c.gap_ticks;
    limit   = now + c.lead_ticks;
    ok      = free_at < limit;
    mine    = (elem == imk_pkg::ELEM_DIT) ? s.dit_pending : s.dah_pending;
    other   = (elem == imk_pkg::ELEM_DIT) ? s.dah_pending : s.dit_pending;
    mine_n  = mine;
    go      = 1'b0;
    case (cls)
      imk_pkg::CLS_ON_CHANGED: begin
        if (ok) begin
          go = 1'b1;
        end else if (s.last_element != elem) begin
          mine_n = 1'b1;
        end
      end
      imk_pkg::CLS_ON: begin
        if (ok && !other) begin
          mine_n = 1'b0;
          go     = 1'b1;
        end
      end
      default: begin
        if (mine && ok && !other) begin
          mine_n = 1'b0;
          go     = 1'b1;
        end
      end
    endcase
    if (go) begin
      start           = (now > free_at) ? now : free_at;
      r.element_start = start;
      r.element_end   = start + len;
      r.last_element  = elem;
    end
    if (elem == imk_pkg::ELEM_DIT) begin
      r.dit_pending = mine_n;
    end else begin
      r.dah_pending = mine_n;
    end
    return r;
  endfunction

  logic            dit_lvl;
  logic            dah_lvl;
  imk_pkg::cls_t   dit_cls;
  imk_pkg::cls_t   dah_cls;
  logic            dit_first;
  imk_pkg::state_t base;
  imk_pkg::state_t pass1;
  imk_pkg::state_t pass2;
  logic            active;

  always_comb begin
    dit_lvl = cfg.paddle_swap ? dah_pressed : dit_pressed;
    dah_lvl = cfg.paddle_swap ? dit_pressed : dah_pressed;
    dit_cls = classify(dit_lvl, cur.dit_level_prev);
    dah_cls = classify(dah_lvl, cur.dah_level_prev);

    base                = cur;
    base.dit_level_prev = dit_lvl;
    base.dah_level_prev = dah_lvl;

    dit_first = (cur.last_element == imk_pkg::ELEM_DIT) ? !cfg.iambic_mode
                                                         : cfg.iambic_mode;
    if (dit_first) begin
      pass1 = handle(base, imk_pkg::ELEM_DIT, dit_cls, cfg.dit_ticks, now_ticks, cfg);
      pass2 = handle(pass1, imk_pkg::ELEM_DAH, dah_cls, cfg.dah_ticks, now_ticks, cfg);
    end else begin
      pass1 = handle(base, imk_pkg::ELEM_DAH, dah_cls, cfg.dah_ticks, now_ticks, cfg);
      pass2 = handle(pass1, imk_pkg::ELEM_DIT, dit_cls, cfg.dit_ticks, now_ticks, cfg);
    end

    // Key follows the flag of the last scheduled element only.
    nxt          = pass2;
    res.key_edge = imk_pkg::EDGE_NONE;
    active = (now_ticks >= pass2.element_start) && (now_ticks < pass2.element_end);
    unique case (pass2.last_element)
      imk_pkg::ELEM_DIT: begin
        if (!active && pass2.dit_keyed) begin
          nxt.dit_keyed = 1'b0;
          res.key_edge  = imk_pkg::EDGE_RELEASE;
        end else if (active && !pass2.dit_keyed) begin
          nxt.dit_keyed = 1'b1;
          res.key_edge  = imk_pkg::EDGE_PRESS;
        end
      end
      imk_pkg::ELEM_DAH: begin
        if (!active && pass2.dah_keyed) begin
          nxt.dah_keyed = 1'b0;
          res.key_edge  = imk_pkg::EDGE_RELEASE;
        end else if (active && !pass2.dah_keyed) begin
          nxt.dah_keyed = 1'b1;
          res.key_edge  = imk_pkg::EDGE_PRESS;
        end
      end
      default: ;
    endcase

    res.current_element = pass2.last_element;
    res.dit_waiting     = pass2.dit_pending;
    res.dah_waiting     = pass2.dah_pending;
  end

endmodule
